>>> design/tcgb_pkg.sv
// ----------------------------------------------------------------------------
// tcgb_pkg
// Shared types and constants of the text cursor glyph blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgb_pkg;

  localparam logic [2:0] CMD_TEXT    = 3'd0;
  localparam logic [2:0] CMD_RAW     = 3'd1;
  localparam logic [2:0] CMD_SET     = 3'd2;
  localparam logic [2:0] CMD_BCD_SUP = 3'd3;
  localparam logic [2:0] CMD_BCD_PAD = 3'd4;

  localparam logic [7:0] CHR_NUL   = 8'd0;
  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_ZERO  = 8'd48;

  localparam logic [7:0] SPACE_ADV   = 8'd6;
  localparam logic [7:0] GLYPH_SIZE  = 8'd8;
  localparam logic [7:0] SCREEN_COLS = 8'd128;

  localparam logic REG_LINE_START   = 1'b0;
  localparam logic REG_COLOR_OFFSET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emits;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/tcgb_if.sv
// ----------------------------------------------------------------------------
// tcgb_if
// Valid/ready channels for command items and glyph blit items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcgb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  char_code;
  logic [6:0]  new_x;
  logic [7:0]  new_y;
  logic [15:0] bcd_value;

  modport source (
    output valid, cmd, char_code, new_x, new_y, bcd_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, new_x, new_y, bcd_value,
    output ready
  );
endinterface

interface tcgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] screen_x;
  logic [7:0] screen_y;
  logic [6:0] glyph_x;
  logic [6:0] glyph_y;
  logic       last;

  modport source (
    output valid, screen_x, screen_y, glyph_x, glyph_y, last,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, glyph_x, glyph_y, last,
    output ready
  );
endinterface

`default_nettype wire

>>> design/tcgb_ctrl.sv
// ----------------------------------------------------------------------------
// tcgb_ctrl
// Controller: takes items while idle and steps the blit datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tcgb_pkg::dp_status_t status_i,
  output tcgb_pkg::ctrl_cmd_t      cmd_o
);

  tcgb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcgb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcgb_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.emits) state_d = tcgb_pkg::ST_EMIT;
      end
      tcgb_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.last) state_d = tcgb_pkg::ST_IDLE;
      end
      default: state_d = tcgb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      tcgb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tcgb_pkg::ST_EMIT: begin
        cmd_o.step = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/tcgb_dp.sv
// ----------------------------------------------------------------------------
// tcgb_dp
// Datapath: cursor state, item latch, wrap and advance, blit output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgb_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcgb_pkg::ctrl_cmd_t cmd_i,
  output tcgb_pkg::dp_status_t     status_o,
  input  wire logic [7:0]          line_start_x_i,
  input  wire logic [7:0]          color_offset_i,
  input  wire logic [2:0]          cmd_code_i,
  input  wire logic [7:0]          char_code_i,
  input  wire logic [6:0]          new_x_i,
  input  wire logic [7:0]          new_y_i,
  input  wire logic [15:0]         bcd_value_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [7:0]               screen_x_o,
  output logic [7:0]               screen_y_o,
  output logic [6:0]               glyph_x_o,
  output logic [6:0]               glyph_y_o,
  output logic                     last_o
);

  logic [7:0]  cursor_x_q, cursor_x_d;
  logic [7:0]  cursor_y_q, cursor_y_d;
  logic [7:0]  wrap_x_q, wrap_x_d;
  logic [7:0]  width_q, width_d;

  logic [7:0]  char_q;
  logic        text_q;
  logic        bcd_mode_q;
  logic [15:0] bcd_q;
  logic [1:0]  cnt_q, cnt_d;

  logic        out_valid_q;
  logic [7:0]  screen_x_q, screen_y_q;
  logic [6:0]  glyph_x_q, glyph_y_q;
  logic        last_q;

  logic [8:0]  limit;
  logic        wrap;
  logic [7:0]  wx, wy, code, cell_code;
  logic        emits;

  // Wrap and advance for the next blit of the item
  always_comb begin
    limit = {1'b0, width_q} + {1'b0, line_start_x_i};
    if (text_q) begin
      wrap = ({1'b0, cursor_x_q} + {1'b0, tcgb_pkg::GLYPH_SIZE}) >= limit;
    end else begin
      wrap = {1'b0, cursor_x_q} >= limit;
    end
    wx = cursor_x_q;
    wy = cursor_y_q;
    if (wrap) begin
      wx = text_q ? wrap_x_q : cursor_x_q - width_q;
      wy = cursor_y_q + tcgb_pkg::GLYPH_SIZE;
    end
    code = bcd_mode_q ? tcgb_pkg::CHR_ZERO + {4'h0, bcd_q[15:12]} : char_q;
    cell_code = code + color_offset_i;
  end

  always_comb begin
    emits = 1'b0;
    cnt_d = 2'd0;
    unique case (cmd_code_i)
      tcgb_pkg::CMD_TEXT: begin
        emits = (char_code_i != tcgb_pkg::CHR_NUL) && (char_code_i != tcgb_pkg::CHR_SPACE) &&
                (char_code_i != tcgb_pkg::CHR_LF) && (char_code_i != tcgb_pkg::CHR_CR);
      end
      tcgb_pkg::CMD_RAW: emits = 1'b1;
      tcgb_pkg::CMD_BCD_SUP: begin
        emits = 1'b1;
        if (bcd_value_i[15:12] != 4'h0)     cnt_d = 2'd3;
        else if (bcd_value_i[11:8] != 4'h0) cnt_d = 2'd2;
        else if (bcd_value_i[7:4] != 4'h0)  cnt_d = 2'd1;
        else                                cnt_d = 2'd0;
      end
      tcgb_pkg::CMD_BCD_PAD: begin
        emits = 1'b1;
        cnt_d = 2'd3;
      end
      default: ;
    endcase
  end

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    wrap_x_d   = wrap_x_q;
    width_d    = width_q;
    if (cmd_i.load) begin
      unique case (cmd_code_i)
        tcgb_pkg::CMD_TEXT: begin
          if (char_code_i == tcgb_pkg::CHR_SPACE) begin
            cursor_x_d = cursor_x_q + tcgb_pkg::SPACE_ADV;
          end else if (char_code_i == tcgb_pkg::CHR_LF) begin
            cursor_y_d = cursor_y_q + tcgb_pkg::GLYPH_SIZE;
          end else if (char_code_i == tcgb_pkg::CHR_CR) begin
            cursor_x_d = line_start_x_i;
          end
        end
        tcgb_pkg::CMD_SET: begin
          cursor_x_d = {1'b0, new_x_i};
          wrap_x_d   = {1'b0, new_x_i};
          cursor_y_d = new_y_i;
          width_d    = tcgb_pkg::SCREEN_COLS - {1'b0, new_x_i};
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      cursor_x_d = wx + tcgb_pkg::GLYPH_SIZE;
      cursor_y_d = wy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      wrap_x_q    <= '0;
      width_q     <= tcgb_pkg::SCREEN_COLS;
      out_valid_q <= 1'b0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      wrap_x_q   <= wrap_x_d;
      width_q    <= width_d;
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q     <= char_code_i;
      text_q     <= cmd_code_i == tcgb_pkg::CMD_TEXT;
      bcd_mode_q <= (cmd_code_i == tcgb_pkg::CMD_BCD_SUP) ||
                    (cmd_code_i == tcgb_pkg::CMD_BCD_PAD);
      cnt_q      <= cnt_d;
      bcd_q      <= bcd_value_i << {2'd3 - cnt_d, 2'b00};
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 2'd1;
      bcd_q <= {bcd_q[11:0], 4'h0};
    end
    if (cmd_i.step) begin
      screen_x_q <= wx;
      screen_y_q <= wy;
      glyph_x_q  <= {cell_code[3:0], 3'b000};
      glyph_y_q  <= {cell_code[7:4], 3'b000};
      last_q     <= cnt_q == 2'd0;
    end
  end

  assign status_o.emits    = emits;
  assign status_o.last     = cnt_q == 2'd0;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = screen_x_q;
  assign screen_y_o  = screen_y_q;
  assign glyph_x_o   = glyph_x_q;
  assign glyph_y_o   = glyph_y_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> design/text_cursor_glyph_blitter.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_blitter
// Turns text, raw, cursor and BCD command items into 8x8 glyph blit items.
// ----------------------------------------------------------------------------
// Commands that give no blit (cursor moves, set cursor, unknown codes) take
// effect at the edge that accepts them and the block is ready again the next
// cycle. A text or raw character is accepted and then gives one blit; a BCD
// value is accepted and then gives one blit per printed digit (up to 4), as a
// single wrap/advance unit forms one blit per cycle with the cursor it leaves.
// A stalled output holds that unit. The next item is accepted while the final
// blit still waits in the output register.
`default_nettype none

module text_cursor_glyph_blitter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tcgb_in_if.sink          in_i,
  tcgb_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] line_start_x_q;
  logic [7:0] color_offset_q;

  tcgb_pkg::ctrl_cmd_t  ctrl_cmd;
  tcgb_pkg::dp_status_t dp_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_x_q <= '0;
      color_offset_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tcgb_pkg::REG_LINE_START:   line_start_x_q <= pwdata[7:0];
        tcgb_pkg::REG_COLOR_OFFSET: color_offset_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tcgb_pkg::REG_LINE_START:   prdata = {24'h0, line_start_x_q};
      tcgb_pkg::REG_COLOR_OFFSET: prdata = {24'h0, color_offset_q};
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  tcgb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  tcgb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .line_start_x_i (line_start_x_q),
    .color_offset_i (color_offset_q),
    .cmd_code_i     (in_i.cmd),
    .char_code_i    (in_i.char_code),
    .new_x_i        (in_i.new_x),
    .new_y_i        (in_i.new_y),
    .bcd_value_i    (in_i.bcd_value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .screen_x_o     (out_o.screen_x),
    .screen_y_o     (out_o.screen_y),
    .glyph_x_o      (out_o.glyph_x),
    .glyph_y_o      (out_o.glyph_y),
    .last_o         (out_o.last)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.step && dp_status.last) |=> in_i.ready)
    else $error("not ready after final blit of an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.step |=> out_o.valid)
    else $error("blit step did not fill output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd == tcgb_pkg::CMD_BCD_PAD) |=> !in_i.ready)
    else $error("padded BCD item did not start blitting");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text cursor glyph blitter. Drives command
// items through random idle and stall bursts, tracks the text cursor in a
// local copy and checks every glyph blit item, field by field, in order.
// Register writes through the APB port happen only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tcgb_pkg::*;

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         HOLD_CYCLES   = 200;
  localparam logic [2:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI  = 3'd7;
  localparam logic [7:0] CHR_PRINT_LO  = 8'd33;
  localparam logic [7:0] CHR_PRINT_HI  = 8'd126;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  ch;
    logic [6:0]  nx;
    logic [7:0]  ny;
    logic [15:0] val;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] screen_x;
    logic [7:0] screen_y;
    logic [6:0] glyph_x;
    logic [6:0] glyph_y;
    logic       last;
  } blit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcgb_in_if  in_if ();
  tcgb_out_if out_if ();

  text_cursor_glyph_blitter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0] line_start;
  logic [7:0] color_off;
  logic [7:0] cur_x;
  logic [7:0] cur_y;
  logic [7:0] wrap_x;
  logic [7:0] print_w;

  blit_t      glyph_q[$];
  blit_t      item_blits[$];
  logic [7:0] ctl_chars[4] = '{CHR_NUL, CHR_SPACE, CHR_LF, CHR_CR};

  int err_cnt   = 0;
  int cycle_cnt = 0;
  bit src_idle_en;
  bit snk_stall_en;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (snk_stall_en && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : blit_check
    blit_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (glyph_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected blit: expected none, actual x=%0d y=%0d", $time,
                 out_if.screen_x, out_if.screen_y);
      end else begin
        want = glyph_q.pop_front();
        check_field("screen_x", want.screen_x, out_if.screen_x);
        check_field("screen_y", want.screen_y, out_if.screen_y);
        check_field("glyph_x", want.glyph_x, out_if.glyph_x);
        check_field("glyph_y", want.glyph_y, out_if.glyph_y);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  function automatic void put_glyph(logic [7:0] code);
    blit_t      b;
    logic [7:0] cell_code;
    cell_code  = code + color_off;
    b.screen_x = cur_x;
    b.screen_y = cur_y;
    b.glyph_x  = {cell_code[3:0], 3'b000};
    b.glyph_y  = {cell_code[7:4], 3'b000};
    b.last     = 1'b0;
    item_blits.push_back(b);
    cur_x = cur_x + GLYPH_SIZE;
  endfunction

  function automatic void put_raw(logic [7:0] code);
    if (int'(cur_x) >= int'(print_w) + int'(line_start)) begin
      cur_x = cur_x - print_w;
      cur_y = cur_y + GLYPH_SIZE;
    end
    put_glyph(code);
  endfunction

  function automatic void predict_blits(cmd_item_t it);
    blit_t      b;
    logic [3:0] nib;
    bit         started;
    item_blits.delete();
    case (it.cmd)
      CMD_TEXT: begin
        if (it.ch == CHR_SPACE) begin
          cur_x = cur_x + SPACE_ADV;
        end else if (it.ch == CHR_LF) begin
          cur_y = cur_y + GLYPH_SIZE;
        end else if (it.ch == CHR_CR) begin
          cur_x = line_start;
        end else if (it.ch != CHR_NUL) begin
          if (int'(cur_x) + int'(GLYPH_SIZE) >= int'(print_w) + int'(line_start)) begin
            cur_x = wrap_x;
            cur_y = cur_y + GLYPH_SIZE;
          end
          put_glyph(it.ch);
        end
      end
      CMD_RAW: begin
        put_raw(it.ch);
      end
      CMD_SET: begin
        cur_x   = {1'b0, it.nx};
        wrap_x  = {1'b0, it.nx};
        cur_y   = it.ny;
        print_w = SCREEN_COLS - {1'b0, it.nx};
      end
      CMD_BCD_SUP, CMD_BCD_PAD: begin
        started = (it.cmd == CMD_BCD_PAD);
        if (!started && it.val == 16'd0) begin
          put_raw(CHR_ZERO);
        end else begin
          for (int d = 3; d >= 0; d--) begin
            nib = it.val[4*d +: 4];
            if (nib != 4'd0 || started) begin
              started = 1'b1;
              put_raw(CHR_ZERO + 8'(nib));
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (item_blits.size() > 0) begin
      b      = item_blits.pop_back();
      b.last = 1'b1;
      item_blits.push_back(b);
    end
    foreach (item_blits[i]) glyph_q.push_back(item_blits[i]);
  endfunction

  function automatic cmd_item_t mk(logic [2:0] cmd, logic [7:0] ch, logic [6:0] nx,
                                   logic [7:0] ny, logic [15:0] val);
    cmd_item_t it;
    it.cmd = cmd;
    it.ch  = ch;
    it.nx  = nx;
    it.ny  = ny;
    it.val = val;
    return it;
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int        pick;
    it   = mk(CMD_TEXT, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.ch = 8'($urandom_range(CHR_PRINT_LO, CHR_PRINT_HI));
    end else if (pick < 45) begin
      it.ch = ctl_chars[$urandom_range(0, 3)];
    end else if (pick < 55) begin
      it.cmd = CMD_TEXT;
    end else if (pick < 67) begin
      it.cmd = CMD_RAW;
    end else if (pick < 73) begin
      it.cmd = CMD_SET;
    end else if (pick < 95) begin
      it.cmd = $urandom_range(0, 1) ? CMD_BCD_PAD : CMD_BCD_SUP;
      if ($urandom_range(0, 1)) it.val = it.val >> (4 * $urandom_range(0, 4));
    end else begin
      it.cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    end
    return it;
  endfunction

  task automatic send_cmd(cmd_item_t it);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= it.cmd;
    in_if.char_code <= it.ch;
    in_if.new_x     <= it.nx;
    in_if.new_y     <= it.ny;
    in_if.bcd_value <= it.val;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    predict_blits(it);
  endtask

  task automatic send_random(int count);
    repeat (count) send_cmd(rand_item());
  endtask

  task automatic send_string();
    cmd_item_t it;
    it = mk(CMD_SET, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    send_cmd(it);
    it.cmd = CMD_TEXT;
    repeat ($urandom_range(4, 16)) begin
      if ($urandom_range(0, 5) == 0) it.ch = ctl_chars[$urandom_range(1, 3)];
      else it.ch = 8'($urandom_range(CHR_PRINT_LO, CHR_PRINT_HI));
      send_cmd(it);
    end
    it.ch = CHR_NUL;
    send_cmd(it);
  endtask

  task automatic drain_blits();
    in_if.valid <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_LINE_START) line_start = value;
    else color_off = value;
  endtask

  task automatic test_directed();
    send_cmd(mk(CMD_TEXT, "A", 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, CHR_NUL, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, CHR_SPACE, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, CHR_LF, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, CHR_CR, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, 8'hFF, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_RAW, 8'h00, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_RAW, 8'hFF, 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_SET, 8'd0, 7'd127, 8'd255, 16'hFFFF));
    send_cmd(mk(CMD_TEXT, "B", 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_RAW, "C", 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_SET, 8'd0, 7'd120, 8'd0, 16'd0));
    send_cmd(mk(CMD_TEXT, "D", 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_RAW, "E", 7'd0, 8'd0, 16'd0));
    send_cmd(mk(CMD_BCD_SUP, 8'd0, 7'd0, 8'd0, 16'h0000));
    send_cmd(mk(CMD_BCD_SUP, 8'd0, 7'd0, 8'd0, 16'h0009));
    send_cmd(mk(CMD_BCD_SUP, 8'd0, 7'd0, 8'd0, 16'hFFFF));
    send_cmd(mk(CMD_BCD_SUP, 8'd0, 7'd0, 8'd0, 16'h0100));
    send_cmd(mk(CMD_BCD_PAD, 8'd0, 7'd0, 8'd0, 16'h0000));
    send_cmd(mk(CMD_BCD_PAD, 8'd0, 7'd0, 8'd0, 16'h1234));
    send_cmd(mk(CMD_UNDEF_LO, 8'hFF, 7'd127, 8'hFF, 16'hFFFF));
    send_cmd(mk(CMD_UNDEF_HI, 8'h41, 7'd5, 8'd9, 16'h0123));
    send_cmd(mk(CMD_SET, 8'd0, 7'd0, 8'd0, 16'd0));
    drain_blits();
  endtask

  task automatic test_register_sweep();
    logic [7:0] starts[5];
    logic [7:0] colors[5];
    starts = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom_range(0, 255))};
    colors = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom_range(0, 255))};
    foreach (starts[i]) begin
      drain_blits();
      write_reg(REG_LINE_START, starts[i]);
      write_reg(REG_COLOR_OFFSET, colors[i]);
      send_string();
      send_random(40);
    end
    drain_blits();
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    send_random(30);
    drain_blits();
  endtask

  task automatic test_sender_pause();
    repeat (2) begin
      send_string();
      send_random(15);
      drain_blits();
    end
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    send_string();
    send_random(50);
    drain_blits();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= CMD_TEXT;
    in_if.char_code <= '0;
    in_if.new_x     <= '0;
    in_if.new_y     <= '0;
    in_if.bcd_value <= '0;
    line_start   = 8'd0;
    color_off    = 8'd0;
    cur_x        = 8'd0;
    cur_y        = 8'd0;
    wrap_x       = 8'd0;
    print_w      = SCREEN_COLS;
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    hold_req     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_sweep();
    test_output_hold();
    test_sender_pause();
    test_full_rate();

    if (err_cnt == 0 && glyph_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> text_cursor_glyph_blitter.f
design/tcgb_pkg.sv
design/tcgb_if.sv
design/tcgb_ctrl.sv
design/tcgb_dp.sv
design/text_cursor_glyph_blitter.sv
sim/testbench.sv
